// File: hdl/maxmin_window_filter_core_assert.svh
// Assertion macros shared by the filter modules. They expect clk and rst_n in scope.
`ifndef MAXMIN_WINDOW_FILTER_CORE_ASSERT_SVH
`define MAXMIN_WINDOW_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MMF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property check failed");
`define MMF_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define MMF_ASSERT(lbl, prop)
`define MMF_NEVER(lbl, cond)
`endif

`endif

// File: hdl/mmf_pkg.sv
package mmf_pkg;

    localparam int W_W        = 11;
    localparam int H_W        = 13;
    localparam int R_W        = 2;
    localparam int CFG_DATA_W = 13;
    localparam int LAG_W      = 13;
    localparam int ROW_W      = 14;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_WINDOW_RADIUS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } pix_t;

    typedef struct packed {
        pix_t mx;
        pix_t mn;
    } span_t;

    typedef struct packed {
        logic [7:0] diff_a;
        logic [7:0] diff_b;
        logic [7:0] diff_c;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic emit;
        logic frame_end;
    } item_ctrl_t;

    typedef struct packed {
        logic s1_emit;
        logic s2_emit;
    } pend_t;

endpackage

// File: hdl/mmf_line_buf.sv
module mmf_line_buf #(
    parameter int MAX_WIDTH = 1024,
    parameter int NUM_SLOTS = 7
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_SLOTS)-1:0] wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  mmf_pkg::pix_t                wr_data,
    input  logic                         rd_en,
    output mmf_pkg::pix_t                rd_data [NUM_SLOTS]
);
    import mmf_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);

    // One row memory per ring slot; every slot is read at the same column.
    for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
        pix_t mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_slot == SW'(s)))
            begin
                mem[addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_data[s] <= mem[addr];
            end
        end
    end

endmodule

// File: hdl/mmf_window.sv
module mmf_window #(
    parameter int NUM_SLOTS = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  mmf_pkg::item_ctrl_t    ctrl,
    input  logic                   pix_en,
    input  mmf_pkg::pix_t          pix,
    input  logic [NUM_SLOTS-1:0]   pmask,
    input  logic [NUM_SLOTS-1:0]   hmask,
    input  mmf_pkg::pix_t          ring [NUM_SLOTS],
    output logic                   res_valid,
    output mmf_pkg::result_t       res,
    output mmf_pkg::pend_t         pend
);
    import mmf_pkg::*;

    function automatic span_t fold(span_t s, pix_t hi, pix_t lo);
        span_t o;
        o = s;
        if (hi.a > o.mx.a) o.mx.a = hi.a;
        if (hi.b > o.mx.b) o.mx.b = hi.b;
        if (hi.c > o.mx.c) o.mx.c = hi.c;
        if (lo.a < o.mn.a) o.mn.a = lo.a;
        if (lo.b < o.mn.b) o.mn.b = lo.b;
        if (lo.c < o.mn.c) o.mn.c = lo.c;
        return o;
    endfunction

    logic                 v1_reg;
    item_ctrl_t           ctrl1_reg;
    logic                 pixen1_reg;
    pix_t                 pix1_reg;
    logic [NUM_SLOTS-1:0] pmask1_reg;
    logic [NUM_SLOTS-1:0] hmask1_reg;

    logic                 v2_reg;
    item_ctrl_t           ctrl2_reg;
    span_t                span2_reg;
    logic [NUM_SLOTS-1:0] hmask2_reg;

    // Column spans of the previous positions, newest at index 1.
    span_t                hist_reg [1:NUM_SLOTS-1];

    span_t                vspan;
    span_t                hspan;

    // Vertical reduction over the clipped rows of one column.
    always_comb
    begin
        vspan.mx = '0;
        vspan.mn = '1;
        if (pixen1_reg)
        begin
            vspan = fold(vspan, pix1_reg, pix1_reg);
        end
        for (int p = 0; p < NUM_SLOTS; p++)
        begin
            if (pmask1_reg[p])
            begin
                vspan = fold(vspan, ring[p], ring[p]);
            end
        end
    end

    // Horizontal reduction over the column spans that lie in the output row.
    always_comb
    begin
        hspan.mx = '0;
        hspan.mn = '1;
        if (hmask2_reg[0])
        begin
            hspan = fold(hspan, span2_reg.mx, span2_reg.mn);
        end
        for (int k = 1; k < NUM_SLOTS; k++)
        begin
            if (hmask2_reg[k])
            begin
                hspan = fold(hspan, hist_reg[k].mx, hist_reg[k].mn);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            ctrl1_reg <= '0;
            v2_reg    <= 1'b0;
            ctrl2_reg <= '0;
        end
        else
        begin
            v1_reg <= take;
            if (take)
            begin
                ctrl1_reg <= ctrl;
            end
            v2_reg <= v1_reg;
            if (v1_reg)
            begin
                ctrl2_reg <= ctrl1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pixen1_reg <= pix_en;
            pix1_reg   <= pix;
            pmask1_reg <= pmask;
            hmask1_reg <= hmask;
        end
        if (v1_reg)
        begin
            span2_reg  <= vspan;
            hmask2_reg <= hmask1_reg;
        end
        if (v2_reg)
        begin
            hist_reg[1] <= span2_reg;
            for (int k = 2; k < NUM_SLOTS; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    assign res_valid     = v2_reg && ctrl2_reg.emit;
    assign res.diff_a    = hspan.mx.a - hspan.mn.a;
    assign res.diff_b    = hspan.mx.b - hspan.mn.b;
    assign res.diff_c    = hspan.mx.c - hspan.mn.c;
    assign res.frame_end = ctrl2_reg.frame_end;
    assign pend.s1_emit  = v1_reg && ctrl1_reg.emit;
    assign pend.s2_emit  = v2_reg && ctrl2_reg.emit;

endmodule

// File: hdl/mmf_out_fifo.sv
`include "maxmin_window_filter_core_assert.svh"

module mmf_out_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  mmf_pkg::result_t                wr_data,
    input  logic                            rd_en,
    output logic                            rd_valid,
    output mmf_pkg::result_t                rd_data,
    output logic [mmf_pkg::FIFO_CW-1:0]     count
);
    import mmf_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   wr_ptr_reg;
    logic [FIFO_PW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   cnt_reg;
    logic                 pop;

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign count    = cnt_reg;
    assign pop      = rd_en && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!wr_en && pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `MMF_NEVER(a_fifo_overflow, wr_en && !pop && (cnt_reg == FIFO_CW'(FIFO_DEPTH)))
    `MMF_ASSERT(a_fifo_ptrs_empty, (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

// File: hdl/maxmin_window_filter_core.sv
// Per-channel max-minus-min filter over a (2r+1)x(2r+1) window, clipped at the
// image borders. Pixels enter in raster order at one item per clock when not
// stalled by in_ready; each item after the first r*W+r of a frame yields the
// result for the next output pixel, and drain items (op=1) after the last pixel
// of a frame flush the remaining results. A drain sent while the frame is still
// being filled is dropped. An item's result passes the column and window stages
// and a four-deep output queue; the input keeps flowing while results wait, up
// to four in all. The rate is set by the 2*MAX_RADIUS+1 row memories, each read
// once and written at most once per clock. Any register write restarts the
// frame; write registers only while the block is idle.
`include "maxmin_window_filter_core_assert.svh"

module maxmin_window_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_index,
    input  logic [mmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [7:0]                       chan_a,
    input  logic [7:0]                       chan_b,
    input  logic [7:0]                       chan_c,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       diff_a,
    output logic [7:0]                       diff_b,
    output logic [7:0]                       diff_c,
    output logic                             frame_end
);
    import mmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NS = 2 * MAX_RADIUS + 1;
    localparam int SW = $clog2(NS);
    localparam int JW = SW + 1;
    localparam logic [W_W-1:0] W_RESET = W_W'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
    localparam logic [H_W-1:0] H_RESET = H_W'(1024);
    localparam logic [R_W-1:0] R_RESET = R_W'(1);

    logic [W_W-1:0]   w_reg, w_next;
    logic [H_W-1:0]   h_reg, h_next;
    logic [R_W-1:0]   r_reg, r_next;
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic [H_W-1:0]   out_row_reg, out_row_next;
    logic [LAG_W-1:0] lead_reg, lead_next;

    logic [W_W-1:0]   cfg_w;
    logic [H_W-1:0]   cfg_h;
    logic [R_W-1:0]   cfg_r;
    logic             cfg_restart;

    logic             fire, take, in_frame, emit, last;
    logic [LAG_W-1:0] lag;
    logic [CW:0]      in_col_inc, out_col_inc;
    logic [NS-1:0]    pmask, hmask;
    item_ctrl_t       ctrl;
    pix_t             pix;
    pix_t             ring_data [NS];
    pend_t            pend;
    logic             res_valid;
    result_t          res;
    result_t          out_res;
    logic [FIFO_CW-1:0] fifo_cnt;
    logic [FIFO_CW-1:0] used;

    // Register writes: zero width and height become one; width and radius are clamped.
    always_comb
    begin
        cfg_w = cfg_data[W_W-1:0];
        if (cfg_w == '0)
        begin
            cfg_w = W_W'(1);
        end
        else if (int'(cfg_w) > MAX_WIDTH)
        begin
            cfg_w = W_W'(MAX_WIDTH);
        end
        cfg_h = cfg_data[H_W-1:0];
        if (cfg_h == '0)
        begin
            cfg_h = H_W'(1);
        end
        cfg_r = cfg_data[R_W-1:0];
        if (int'(cfg_r) > MAX_RADIUS)
        begin
            cfg_r = R_W'(MAX_RADIUS);
        end
    end

    always_comb
    begin
        w_next      = w_reg;
        h_next      = h_reg;
        r_next      = r_reg;
        cfg_restart = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    w_next      = cfg_w;
                    cfg_restart = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    h_next      = cfg_h;
                    cfg_restart = 1'b1;
                end
                CFG_WINDOW_RADIUS:
                begin
                    r_next      = cfg_r;
                    cfg_restart = 1'b1;
                end
                default:
                begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    assign used     = fifo_cnt + FIFO_CW'(pend.s1_emit) + FIFO_CW'(pend.s2_emit);
    assign in_ready = (used < FIFO_CW'(FIFO_DEPTH));
    assign fire     = in_valid && in_ready;
    assign in_frame = (in_row_reg < ROW_W'(h_reg));
    // A drain inside the frame leaves no trace.
    assign take     = fire && !(in_frame && op);

    assign lag         = LAG_W'({2'b00, w_reg} * r_reg) + LAG_W'(r_reg);
    assign emit        = (lead_reg >= lag);
    assign in_col_inc  = {1'b0, in_col_reg} + 1'b1;
    assign out_col_inc = {1'b0, out_col_reg} + 1'b1;
    assign last        = emit && (out_row_reg == h_reg - 1'b1)
                         && (int'(out_col_inc) == int'(w_reg));

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        slot_next    = slot_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lead_next    = lead_reg;
        if (cfg_restart || (take && last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            slot_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
            lead_next    = '0;
        end
        else if (take)
        begin
            if (int'(in_col_inc) >= int'(w_reg))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
                slot_next   = (slot_reg == SW'(NS - 1)) ? '0 : slot_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_inc[CW-1:0];
            end
            if (!emit)
            begin
                lead_next = lead_reg + 1'b1;
            end
            else if (int'(out_col_inc) >= int'(w_reg))
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_inc[CW-1:0];
            end
        end
    end

    // Ring slot p holds the row j back from the current one; it joins the
    // column when that row lies within the radius and inside the frame.
    always_comb
    begin
        logic [JW-1:0] jd;
        for (int p = 0; p < NS; p++)
        begin
            if (slot_reg >= SW'(p))
            begin
                jd = JW'(slot_reg) - JW'(p);
            end
            else
            begin
                jd = JW'(slot_reg) + JW'(NS - p);
            end
            pmask[p] = (slot_reg != SW'(p))
                       && (int'(jd) <= 2 * int'(r_reg))
                       && (int'(in_row_reg) >= int'(jd))
                       && (int'(in_row_reg) < int'(h_reg) + int'(jd));
        end
    end

    // Column span k back from the newest lies at offset r-k from the output column.
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            hmask[k] = (k <= 2 * int'(r_reg))
                       && (int'(out_col_reg) + int'(r_reg) >= k)
                       && (int'(out_col_reg) + int'(r_reg) < int'(w_reg) + k);
        end
    end

    assign ctrl.emit      = emit;
    assign ctrl.frame_end = last;
    assign pix.a          = chan_a;
    assign pix.b          = chan_b;
    assign pix.c          = chan_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= W_RESET;
            h_reg       <= H_RESET;
            r_reg       <= R_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            slot_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            r_reg       <= r_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            slot_reg    <= slot_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lead_reg    <= lead_next;
        end
    end

    mmf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .NUM_SLOTS (NS)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (take && in_frame),
        .wr_slot (slot_reg),
        .addr    (in_col_reg),
        .wr_data (pix),
        .rd_en   (take),
        .rd_data (ring_data)
    );

    mmf_window #(
        .NUM_SLOTS (NS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .ctrl      (ctrl),
        .pix_en    (in_frame),
        .pix       (pix),
        .pmask     (pmask),
        .hmask     (hmask),
        .ring      (ring_data),
        .res_valid (res_valid),
        .res       (res),
        .pend      (pend)
    );

    mmf_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_en    (out_ready),
        .rd_valid (out_valid),
        .rd_data  (out_res),
        .count    (fifo_cnt)
    );

    assign diff_a    = out_res.diff_a;
    assign diff_b    = out_res.diff_b;
    assign diff_c    = out_res.diff_c;
    assign frame_end = out_res.frame_end;

    `MMF_ASSERT(a_last_restarts, (take && last) |=> ((in_row_reg == '0) && (lead_reg == '0)))
    `MMF_ASSERT(a_out_row_in_frame, out_row_reg < h_reg)

endmodule

// File: bench/tb_maxmin_window_filter_core.sv
`timescale 1ns / 100ps

module tb_maxmin_window_filter_core;

    import mmf_pkg::*;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;
    localparam int   RING_ROWS = 10;
    localparam int   LINE_LEN  = 1024;

    typedef struct {
        logic       op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } pixel_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  op = 1'b0;
    logic [7:0]            chan_a = '0;
    logic [7:0]            chan_b = '0;
    logic [7:0]            chan_c = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            diff_a;
    logic [7:0]            diff_b;
    logic [7:0]            diff_c;
    logic                  frame_end;

    maxmin_window_filter_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .op(op),
        .chan_a(chan_a), .chan_b(chan_b), .chan_c(chan_c),
        .out_valid(out_valid), .out_ready(out_ready),
        .diff_a(diff_a), .diff_b(diff_b), .diff_c(diff_c), .frame_end(frame_end)
    );

    pixel_item_t pixel_queue[$];
    result_t     gradient_queue[$];
    int          error_count = 0;
    int          items_made = 0;

    // Shadow of the block: row ring, counters and the clamped settings.
    logic [23:0] ring [0:RING_ROWS-1][0:LINE_LEN-1];
    int unsigned img_w = 1024, img_h = 1024, radius = 1;
    int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

    initial forever #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("tb_maxmin_window_filter_core: errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic restart_counters();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic predict_gradient(input logic iop, input logic [23:0] px);
        int unsigned lag, y0, y1, x0, x1;
        logic [7:0] mx [3];
        logic [7:0] mn [3];
        logic [23:0] s;
        result_t res;
        if (in_row < img_h)
        begin
            if (iop == OP_DRAIN)
                return;
            ring[in_row % RING_ROWS][in_col % LINE_LEN] = px;
        end
        in_col++;
        if (in_col >= img_w)
        begin
            in_col = 0;
            in_row++;
        end
        lag = radius * img_w + radius;
        if (in_row * img_w + in_col <= lag)
            return;
        y0 = out_row >= radius ? out_row - radius : 0;
        y1 = out_row + radius < img_h ? out_row + radius : img_h - 1;
        x0 = out_col >= radius ? out_col - radius : 0;
        x1 = out_col + radius < img_w ? out_col + radius : img_w - 1;
        for (int k = 0; k < 3; k++)
        begin
            mx[k] = 8'd0;
            mn[k] = 8'd255;
        end
        for (int unsigned y = y0; y <= y1; y++)
            for (int unsigned x = x0; x <= x1; x++)
            begin
                s = ring[y % RING_ROWS][x % LINE_LEN];
                for (int k = 0; k < 3; k++)
                begin
                    if (s[23-8*k -: 8] > mx[k]) mx[k] = s[23-8*k -: 8];
                    if (s[23-8*k -: 8] < mn[k]) mn[k] = s[23-8*k -: 8];
                end
            end
        res.diff_a = mx[0] - mn[0];
        res.diff_b = mx[1] - mn[1];
        res.diff_c = mx[2] - mn[2];
        res.frame_end = (out_row == img_h - 1) && (out_col == img_w - 1);
        gradient_queue.push_back(res);
        if (res.frame_end)
            restart_counters();
        else
        begin
            out_col++;
            if (out_col >= img_w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    // Driver: bursts of items separated by random gaps.
    logic item_taken = 1'b0;
    int   burst_left = 8;
    int   gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            item_taken = 1'b1;
            predict_gradient(op, {chan_a, chan_b, chan_c});
        end
    end

    always @(negedge clk)
    begin
        pixel_item_t it;
        if (rst_n && (!in_valid || item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pixel_queue.size() > 0)
            begin
                it = pixel_queue.pop_front();
                in_valid <= 1'b1;
                op <= it.op;
                chan_a <= it.a;
                chan_b <= it.b;
                chan_c <= it.c;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
        item_taken = 1'b0;
    end

    // Receiver stalls follow a random mode that is redrawn whenever its run ends.
    int stall_mode = 0;
    int stall_left = 100;
    int cycle_count = 0;

    always @(negedge clk)
    begin
        cycle_count++;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom % 2);
            2: out_ready <= (cycle_count % 5) != 0;
            default: out_ready <= ($urandom % 8) == 0;
        endcase
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (gradient_queue.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = gradient_queue.pop_front();
                if (diff_a !== want.diff_a)
                    report_mismatch($sformatf("diff_a %0d want %0d", diff_a, want.diff_a));
                if (diff_b !== want.diff_b)
                    report_mismatch($sformatf("diff_b %0d want %0d", diff_b, want.diff_b));
                if (diff_c !== want.diff_c)
                    report_mismatch($sformatf("diff_c %0d want %0d", diff_c, want.diff_c));
                if (frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %0b want %0b",
                                              frame_end, want.frame_end));
            end
        end
    end

    task automatic add_item(input logic iop, input logic [7:0] a, b, c);
        pixel_item_t it;
        it.op = iop;
        it.a = a;
        it.b = b;
        it.c = c;
        pixel_queue.push_back(it);
        items_made++;
    endtask

    task automatic add_random(input logic iop);
        add_item(iop, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    endtask

    // Waits until every item is taken and every result is back, then lets the
    // pipeline empty out.
    task automatic settle();
        while (pixel_queue.size() != 0 || in_valid || gradient_queue.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        int unsigned v;
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_IMAGE_WIDTH:
            begin
                v = value & 32'h7FF;
                img_w = v == 0 ? 1 : (v > LINE_LEN ? LINE_LEN : v);
            end
            CFG_IMAGE_HEIGHT:
            begin
                v = value & 32'h1FFF;
                img_h = v == 0 ? 1 : v;
            end
            default: radius = value & 32'h3;
        endcase
        restart_counters();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input int unsigned w, h, r);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_WINDOW_RADIUS, r);
    endtask

    // One frame plus its drain tail. Noise puts ignored drains inside the frame
    // and pixels in the tail; cut stops the sequence early.
    task automatic add_frame(input bit noise, input bit cut);
        int unsigned n, tail, stop;
        n = img_w * img_h;
        tail = radius * img_w + radius;
        stop = cut ? $urandom_range(0, n + tail - 1) : n + tail;
        for (int unsigned i = 0; i < n + tail && i < stop; i++)
        begin
            if (i < n)
            begin
                if (noise && $urandom % 10 == 0)
                    add_random(OP_DRAIN);
                add_random(OP_PIXEL);
            end
            else
                add_random((noise && $urandom % 3 == 0) ? OP_PIXEL : OP_DRAIN);
        end
    endtask

    initial
    begin
        int unsigned w, h;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme samples in a 3x3 frame, a drain inside the frame
        // that must be ignored, and a pixel past the end that acts as a drain.
        configure(3, 3, 1);
        add_item(OP_PIXEL, 8'd0, 8'd255, 8'd0);
        add_item(OP_PIXEL, 8'd255, 8'd0, 8'd255);
        add_item(OP_DRAIN, 8'd17, 8'd17, 8'd17);
        add_item(OP_PIXEL, 8'd0, 8'd0, 8'd0);
        add_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        add_item(OP_PIXEL, 8'd128, 8'd127, 8'd1);
        add_item(OP_PIXEL, 8'd0, 8'd255, 8'd0);
        add_item(OP_PIXEL, 8'd255, 8'd0, 8'd255);
        add_item(OP_PIXEL, 8'd7, 8'd8, 8'd9);
        add_item(OP_PIXEL, 8'd0, 8'd255, 8'd0);
        add_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        add_item(OP_DRAIN, 8'd0, 8'd0, 8'd0);
        add_item(OP_DRAIN, 8'd0, 8'd0, 8'd0);
        add_item(OP_DRAIN, 8'd0, 8'd0, 8'd0);
        settle();
        // Zero width and height are taken as one; radius zero passes pixels.
        configure(0, 0, 0);
        add_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        add_item(OP_PIXEL, 8'd1, 8'd2, 8'd3);
        settle();
        // Window larger than the image in both directions.
        configure(2, 2, 3);
        add_frame(1'b0, 1'b0);
        settle();
        // Largest height code, then a single row at the clamped full width.
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        configure(2047, 1, 0);
        add_frame(1'b0, 1'b0);
        settle();
        configure(1, 40, 3);
        add_frame(1'b1, 1'b0);
        settle();

        while (items_made < 1200)
        begin
            w = ($urandom % 6 == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            h = ($urandom % 6 == 0) ? $urandom_range(0, 30) : $urandom_range(1, 8);
            configure(w, h, $urandom_range(0, 3));
            repeat ($urandom_range(1, 3))
                add_frame($urandom % 3 == 0, $urandom % 8 == 0);
            if ($urandom % 5 == 0)
                repeat ($urandom_range(1, 5))
                    add_random(1'($urandom % 2));
            settle();
        end

        settle();
        if (gradient_queue.size() != 0)
            report_mismatch("expected results left over");
        if (error_count == 0)
            $display("tb_maxmin_window_filter_core: clean");
        else
            $display("tb_maxmin_window_filter_core: errors");
        $finish;
    end

endmodule
